// ===== design/mf2d_pkg.sv =====
package mf2d_pkg;

   // register field widths
   localparam int IMAGE_WIDTH_W  = 11;
   localparam int IMAGE_HEIGHT_W = 13;
   localparam int WINDOW_HALF_W  = 4;
   localparam int PIXEL_W        = 8;
   localparam int BINS           = 256;

   // csr bus
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // register index (paddr[3:2])
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WINDOW_HALF  = 2'd2;
   localparam logic [1:0] REG_UNUSED       = 2'd3;

   // op codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

endpackage

// ===== design/mf2d_req_if.sv =====
interface mf2d_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [mf2d_pkg::PIXEL_W-1:0]  pixel_value;

   modport source (output valid, output op, output pixel_value, input ready);
   modport sink   (input valid, input op, input pixel_value, output ready);
endinterface

// ===== design/mf2d_rsp_if.sv =====
interface mf2d_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mf2d_pkg::PIXEL_W-1:0]  median_value;
   logic                          last_of_frame;

   modport source (output valid, output median_value, output last_of_frame, input ready);
   modport sink   (input valid, input median_value, input last_of_frame, output ready);
endinterface

// ===== design/mf2d_ram.sv =====
module mf2d_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== design/median_filter_2d_clamped_top.sv =====
// 2-D median filter over one greyscale frame delivered in raster order. Pixels (op = pixel)
// are written into a ring line store of 2*MAX_HALF+1 rows; each result is the median of the
// pixel's square window of reach window_half, cropped at the image edges, taking element
// count/2 of the sorted window (upper median for even counts). Results come out in raster
// order as soon as their window is complete; after the frame, flush transfers (or further
// pixels, which are dropped) drain the remaining results, the last flagged by last_of_frame.
// One item is in flight at a time. An item that yields no result passes from IDLE through
// CHECK and back. An item that drains an already complete window, after passing CHECK when
// its pixel is stored first, clears the histogram memory bin by bin in CLEAR; each element of
// the cropped window (at most 625 elements) is then a line-store read, a histogram read and a
// histogram write-back, and the rank search then walks the histogram from bin 0 up to the
// median bin. A finished result sits in an output register, so the next item is taken while
// it waits. Config writes (APB, byte addresses 0/4/8) restart the frame; the line store keeps
// its contents and needs no clearing pass after reset.
module median_filter_2d_clamped_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HALF   = 12,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   mf2d_req_if.sink                      req_port,
   mf2d_rsp_if.source                    rsp_port,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [mf2d_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [mf2d_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [mf2d_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);

   localparam int WW   = mf2d_pkg::IMAGE_WIDTH_W;
   localparam int HW   = mf2d_pkg::IMAGE_HEIGHT_W;
   localparam int KW   = mf2d_pkg::WINDOW_HALF_W;
   localparam int PW   = mf2d_pkg::PIXEL_W;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int RW   = $clog2(MAX_HEIGHT);
   localparam int RING = 2 * MAX_HALF + 1;
   localparam int RGW  = $clog2(RING);
   localparam int LS_DEPTH = RING * MAX_WIDTH;
   localparam int LSAW = $clog2(LS_DEPTH);
   localparam int CNTW = $clog2(RING * RING + 1);
   localparam int HAW  = $clog2(mf2d_pkg::BINS);
   localparam int XW   = ((RW > HW) ? RW : HW) + 1;
   localparam int CXW  = ((CW > WW) ? CW : WW) + 1;
   localparam int W_RST = (1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH;
   localparam int H_RST = (1024 < MAX_HEIGHT) ? 1024 : MAX_HEIGHT;
   localparam int K_RST = (1 < MAX_HALF) ? 1 : MAX_HALF;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CHECK = 9'b000000010,
      S_CLEAR = 9'b000000100,
      S_LSRD  = 9'b000001000,
      S_HRD   = 9'b000010000,
      S_HWR   = 9'b000100000,
      S_SRD   = 9'b001000000,
      S_SACC  = 9'b010000000,
      S_HOLD  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;
   logic [KW-1:0] half_ff, half_in;

   // frame position
   logic [RW-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RGW-1:0] in_ring_ff, in_ring_in, out_ring_ff, out_ring_in;
   logic           frame_rcv_ff, frame_rcv_in;

   // window walk
   logic [RW-1:0]   cur_r_ff, cur_r_in, r1_ff, r1_in;
   logic [CW-1:0]   cur_c_ff, cur_c_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [RGW-1:0]  cur_ring_ff, cur_ring_in;
   logic [CNTW-1:0] cnt_ff, cnt_in, cum_ff, cum_in;
   logic [HAW-1:0]  sweep_ff, sweep_in, bin_ff, bin_in;
   logic [PW-1:0]   med_ff, med_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [PW-1:0] rsp_med_ff, rsp_med_in;
   logic          rsp_last_ff, rsp_last_in;

   // memories
   logic            ls_we;
   logic [LSAW-1:0] ls_waddr, ls_raddr;
   logic [PW-1:0]   ls_q;
   logic            h_we;
   logic [HAW-1:0]  h_waddr, h_raddr;
   logic [CNTW-1:0] h_wdata, h_q;

   // csr decode
   logic       csr_wr;
   logic [1:0] csr_idx;

   // window readiness and bounds
   logic [XW-1:0]  tr, tr_sum, h_m1;
   logic [CXW-1:0] tc, tc_sum, w_m1;
   logic           out_rdy;
   logic [RW-1:0]  r0;
   logic [CW-1:0]  c0;
   logic [RGW-1:0] d_ring, ring0;
   logic           out_last;
   logic [CNTW-1:0] cum_next;

   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_idx)
         mf2d_pkg::REG_IMAGE_WIDTH:  csr_prdata = mf2d_pkg::CSR_DW'(width_ff);
         mf2d_pkg::REG_IMAGE_HEIGHT: csr_prdata = mf2d_pkg::CSR_DW'(height_ff);
         mf2d_pkg::REG_WINDOW_HALF:  csr_prdata = mf2d_pkg::CSR_DW'(half_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // last row/column of the next output window, clipped to the image
   assign tr_sum = XW'(out_row_ff) + XW'(half_ff);
   assign h_m1   = XW'(height_ff) - XW'(1);
   assign tr     = (tr_sum < h_m1) ? tr_sum : h_m1;
   assign tc_sum = CXW'(out_col_ff) + CXW'(half_ff);
   assign w_m1   = CXW'(width_ff) - CXW'(1);
   assign tc     = (tc_sum < w_m1) ? tc_sum : w_m1;
   assign out_rdy = frame_rcv_ff || (tr < XW'(in_row_ff))
                    || ((tr == XW'(in_row_ff)) && (tc < CXW'(in_col_ff)));

   assign r0 = (out_row_ff >= RW'(half_ff)) ? out_row_ff - RW'(half_ff) : '0;
   assign c0 = (out_col_ff >= CW'(half_ff)) ? out_col_ff - CW'(half_ff) : '0;
   assign d_ring = RGW'(out_row_ff - r0);
   assign ring0  = (out_ring_ff >= d_ring) ? out_ring_ff - d_ring
                                           : RGW'(32'(out_ring_ff) + RING - 32'(d_ring));
   assign out_last = (XW'(out_row_ff) == h_m1) && (CXW'(out_col_ff) == w_m1);
   assign cum_next = cum_ff + h_q;

   assign ls_waddr = LSAW'(32'(in_ring_ff) * MAX_WIDTH) + LSAW'(in_col_ff);
   assign ls_raddr = LSAW'(32'(cur_ring_ff) * MAX_WIDTH) + LSAW'(cur_c_ff);
   assign ls_we    = (state_ff == S_IDLE) && req_port.valid
                     && (req_port.op == mf2d_pkg::OP_PIXEL) && !out_rdy && !frame_rcv_ff;

   // histogram: write in CLEAR/HWR, read in HRD/SRD; a write-back never meets a read of
   // the same bin in flight since the walk is strictly sequenced
   assign h_we    = (state_ff == S_CLEAR) || (state_ff == S_HWR);
   assign h_waddr = (state_ff == S_CLEAR) ? sweep_ff : bin_ff;
   assign h_wdata = (state_ff == S_CLEAR) ? '0 : h_q + CNTW'(1);
   assign h_raddr = (state_ff == S_HRD) ? ls_q : sweep_ff;

   assign req_port.ready         = (state_ff == S_IDLE);
   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.median_value  = rsp_med_ff;
   assign rsp_port.last_of_frame = rsp_last_ff;

   mf2d_ram #(.DEPTH(LS_DEPTH), .WIDTH(PW)) u_line_store (
      .clock   (clock),
      .wr_en   (ls_we),
      .wr_addr (ls_waddr),
      .wr_data (req_port.pixel_value),
      .rd_addr (ls_raddr),
      .rd_data (ls_q)
   );

   mf2d_ram #(.DEPTH(mf2d_pkg::BINS), .WIDTH(CNTW)) u_hist (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_q)
   );

   always_comb begin
      state_in     = state_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      half_in      = half_ff;
      in_row_in    = in_row_ff;
      in_col_in    = in_col_ff;
      in_ring_in   = in_ring_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_ring_in  = out_ring_ff;
      frame_rcv_in = frame_rcv_ff;
      cur_r_in     = cur_r_ff;
      cur_c_in     = cur_c_ff;
      cur_ring_in  = cur_ring_ff;
      r1_in        = r1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      cnt_in       = cnt_ff;
      cum_in       = cum_ff;
      sweep_in     = sweep_ff;
      bin_in       = bin_ff;
      med_in       = med_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_med_in   = rsp_med_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_port.valid) begin
               if (out_rdy) begin
                  sweep_in = '0;
                  state_in = S_CLEAR;
               end else begin
                  if (ls_we) begin
                     if (CXW'(in_col_ff) + CXW'(1) >= CXW'(width_ff)) begin
                        in_col_in = '0;
                        if (XW'(in_row_ff) >= h_m1) begin
                           frame_rcv_in = 1'b1;
                        end else begin
                           in_row_in  = in_row_ff + RW'(1);
                           in_ring_in = (32'(in_ring_ff) == RING - 1) ? '0
                                                                      : in_ring_ff + RGW'(1);
                        end
                     end else begin
                        in_col_in = in_col_ff + CW'(1);
                     end
                  end
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            sweep_in = '0;
            state_in = out_rdy ? S_CLEAR : S_IDLE;
         end
         S_CLEAR: begin
            sweep_in = sweep_ff + HAW'(1);
            if (sweep_ff == '1) begin
               cur_r_in    = r0;
               cur_c_in    = c0;
               cur_ring_in = ring0;
               r1_in       = RW'(tr);
               c0_in       = c0;
               c1_in       = CW'(tc);
               cnt_in      = '0;
               state_in    = S_LSRD;
            end
         end
         S_LSRD: begin
            state_in = S_HRD;
         end
         S_HRD: begin
            bin_in   = ls_q;
            state_in = S_HWR;
         end
         S_HWR: begin
            cnt_in   = cnt_ff + CNTW'(1);
            state_in = S_LSRD;
            if (cur_c_ff == c1_ff) begin
               cur_c_in = c0_ff;
               if (cur_r_ff == r1_ff) begin
                  sweep_in = '0;
                  cum_in   = '0;
                  state_in = S_SRD;
               end else begin
                  cur_r_in    = cur_r_ff + RW'(1);
                  cur_ring_in = (32'(cur_ring_ff) == RING - 1) ? '0 : cur_ring_ff + RGW'(1);
               end
            end else begin
               cur_c_in = cur_c_ff + CW'(1);
            end
         end
         S_SRD: begin
            state_in = S_SACC;
         end
         S_SACC: begin
            cum_in = cum_next;
            if (cum_next > (cnt_ff >> 1)) begin
               med_in   = sweep_ff;
               state_in = S_HOLD;
            end else begin
               sweep_in = sweep_ff + HAW'(1);
               state_in = S_SRD;
            end
         end
         S_HOLD: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_med_in   = med_ff;
               rsp_last_in  = out_last;
               state_in     = S_IDLE;
               if (out_last) begin
                  in_row_in    = '0;
                  in_col_in    = '0;
                  in_ring_in   = '0;
                  out_row_in   = '0;
                  out_col_in   = '0;
                  out_ring_in  = '0;
                  frame_rcv_in = 1'b0;
               end else if (CXW'(out_col_ff) + CXW'(1) >= CXW'(width_ff)) begin
                  out_col_in  = '0;
                  out_row_in  = out_row_ff + RW'(1);
                  out_ring_in = (32'(out_ring_ff) == RING - 1) ? '0 : out_ring_ff + RGW'(1);
               end else begin
                  out_col_in = out_col_ff + CW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // register writes clamp and restart the frame
      if (csr_wr && (csr_idx != mf2d_pkg::REG_UNUSED)) begin
         unique case (csr_idx)
            mf2d_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_pwdata[WW-1:0];
               if (csr_pwdata[WW-1:0] == '0) begin
                  width_in = WW'(1);
               end else if (32'(csr_pwdata[WW-1:0]) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end
            end
            mf2d_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_pwdata[HW-1:0];
               if (csr_pwdata[HW-1:0] == '0) begin
                  height_in = HW'(1);
               end else if (32'(csr_pwdata[HW-1:0]) > MAX_HEIGHT) begin
                  height_in = HW'(MAX_HEIGHT);
               end
            end
            mf2d_pkg::REG_WINDOW_HALF: begin
               half_in = csr_pwdata[KW-1:0];
               if (32'(csr_pwdata[KW-1:0]) > MAX_HALF) begin
                  half_in = KW'(MAX_HALF);
               end
            end
            default: begin
               half_in = half_ff;
            end
         endcase
         in_row_in    = '0;
         in_col_in    = '0;
         in_ring_in   = '0;
         out_row_in   = '0;
         out_col_in   = '0;
         out_ring_in  = '0;
         frame_rcv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WW'(W_RST);
         height_ff    <= HW'(H_RST);
         half_ff      <= KW'(K_RST);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_ring_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         out_ring_ff  <= '0;
         frame_rcv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         half_ff      <= half_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_ring_ff   <= in_ring_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         out_ring_ff  <= out_ring_in;
         frame_rcv_ff <= frame_rcv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_r_ff    <= cur_r_in;
      cur_c_ff    <= cur_c_in;
      cur_ring_ff <= cur_ring_in;
      r1_ff       <= r1_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      cnt_ff      <= cnt_in;
      cum_ff      <= cum_in;
      sweep_ff    <= sweep_in;
      bin_ff      <= bin_in;
      med_ff      <= med_in;
      rsp_med_ff  <= rsp_med_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== design/mf2d_checker.sv =====
module mf2d_assertions (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mf2d_pkg::PIXEL_W-1:0] rsp_median_value,
   input logic                         rsp_last_of_frame
);

   // one item at a time: ready drops after each accepted transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a new result only appears after the block was busy
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_median_value) && $stable(rsp_last_of_frame))
      else $error("stalled response changed");

endmodule

bind median_filter_2d_clamped_top mf2d_assertions u_mf2d_assertions (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_port.valid),
   .req_ready         (req_port.ready),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_median_value  (rsp_port.median_value),
   .rsp_last_of_frame (rsp_port.last_of_frame)
);
